/* sv/tfn_pkg.sv */
// Package of the triangle face normal core: request types and pipeline sizes.
// No dependencies; used by the interfaces and by triangle_face_normal_core.
package tfn_pkg;

  // One triangle request: three Q8.8 vertices and three vertex indices.
  typedef struct packed {
    logic signed [15:0] p0_x;
    logic signed [15:0] p0_y;
    logic signed [15:0] p0_z;
    logic signed [15:0] p1_x;
    logic signed [15:0] p1_y;
    logic signed [15:0] p1_z;
    logic signed [15:0] p2_x;
    logic signed [15:0] p2_y;
    logic signed [15:0] p2_z;
    logic [15:0]        idx_a;
    logic [15:0]        idx_b;
    logic [15:0]        idx_c;
  } tri_req_t;

  // One result: Q1.14 unit normal, echoed indices and the degenerate flag.
  typedef struct packed {
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [15:0]        out_idx_a;
    logic [15:0]        out_idx_b;
    logic [15:0]        out_idx_c;
    logic               degenerate;
  } norm_rsp_t;

  // Sideband that travels with each request through the pipeline.
  typedef struct packed {
    logic [2:0]  sgn;
    logic        degen;
    logic [15:0] idx_a;
    logic [15:0] idx_b;
    logic [15:0] idx_c;
  } side_t;

  localparam int unsigned DivSteps  = 31;  // quotient bits of a^2 * 2^30 / S
  localparam int unsigned SqrtSteps = 16;  // root bits of a 32-bit radicand
  localparam logic signed [15:0] NormMax = 16'sd16384;

endpackage

/* sv/tfn_if.sv */
// Valid/ready channels of the triangle face normal core.
// Depends on tfn_pkg for the payload types.
interface tfn_in_if;
  logic             valid;
  logic             ready;
  tfn_pkg::tri_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tfn_out_if;
  logic               valid;
  logic               ready;
  tfn_pkg::norm_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/triangle_face_normal_core.sv */
// Triangle face normal core: edges, cross product, exact unit scaling to Q1.14.
// Throughput one request per cycle, except while a result waits to be taken.
// Depth is set by the 31 restoring divide stages and 16 square root stages.
// The whole pipeline advances together and holds when the result is not taken.
// Reset (rst_ni low, asynchronous) clears all valid bits; data is not reset.
// Depends on tfn_pkg and the channel interfaces in tfn_if.sv.
module triangle_face_normal_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  tfn_in_if.sink     in_if,
  tfn_out_if.source  out_if
);
  import tfn_pkg::*;

  // Global advance: the pipeline moves unless the result register is held.
  logic en;
  logic out_valid_q;
  assign en = !out_valid_q || out_if.ready;
  assign in_if.ready = en;

  // Stage 1: edges e1 = p1 - p0 and e2 = p2 - p0.
  logic               v1_q;
  logic signed [16:0] e_q [6];
  side_t              sd1_q;
  // Stage 2: the six cross product terms.
  logic               v2_q;
  logic signed [33:0] pr_q [6];
  side_t              sd2_q;
  // Stage 3: cross product components.
  logic               v3_q;
  logic signed [34:0] c_q [3];
  side_t              sd3_q;
  // Stage 4: magnitudes brought below 2^31.
  logic               v4_q;
  logic [30:0]        a_q [3];
  side_t              sd4_q;
  // Stage 5: squares.
  logic               v5_q;
  logic [61:0]        sq5_q [3];
  side_t              sd5_q;
  // Stage 6: sum of squares.
  logic               v6_q;
  logic [61:0]        sq6_q [3];
  logic [63:0]        s6_q;
  side_t              sd6_q;

  logic [33:0] mag [3];
  logic [33:0] big;
  logic [1:0]  shamt;

  // Magnitudes, the largest one and the common right shift.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = c_q[i][34] ? 34'(-c_q[i]) : 34'(c_q[i]);
    end
    big = mag[0];
    if (mag[1] > big) begin
      big = mag[1];
    end
    if (mag[2] > big) begin
      big = mag[2];
    end
    if (big[33]) begin
      shamt = 2'd3;
    end else if (big[32]) begin
      shamt = 2'd2;
    end else if (big[31]) begin
      shamt = 2'd1;
    end else begin
      shamt = 2'd0;
    end
  end

  // Front valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_if.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  // Front data path.
  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q[0] <= 17'(in_if.data.p1_x) - 17'(in_if.data.p0_x);
      e_q[1] <= 17'(in_if.data.p1_y) - 17'(in_if.data.p0_y);
      e_q[2] <= 17'(in_if.data.p1_z) - 17'(in_if.data.p0_z);
      e_q[3] <= 17'(in_if.data.p2_x) - 17'(in_if.data.p0_x);
      e_q[4] <= 17'(in_if.data.p2_y) - 17'(in_if.data.p0_y);
      e_q[5] <= 17'(in_if.data.p2_z) - 17'(in_if.data.p0_z);
      sd1_q.sgn   <= 3'b000;
      sd1_q.degen <= 1'b0;
      sd1_q.idx_a <= in_if.data.idx_a;
      sd1_q.idx_b <= in_if.data.idx_b;
      sd1_q.idx_c <= in_if.data.idx_c;

      pr_q[0] <= e_q[1] * e_q[5];
      pr_q[1] <= e_q[2] * e_q[4];
      pr_q[2] <= e_q[2] * e_q[3];
      pr_q[3] <= e_q[0] * e_q[5];
      pr_q[4] <= e_q[0] * e_q[4];
      pr_q[5] <= e_q[1] * e_q[3];
      sd2_q   <= sd1_q;

      c_q[0] <= 35'(pr_q[0]) - 35'(pr_q[1]);
      c_q[1] <= 35'(pr_q[2]) - 35'(pr_q[3]);
      c_q[2] <= 35'(pr_q[4]) - 35'(pr_q[5]);
      sd3_q  <= sd2_q;

      for (int i = 0; i < 3; i++) begin
        a_q[i] <= 31'(mag[i] >> shamt);
      end
      sd4_q.sgn   <= {c_q[2][34], c_q[1][34], c_q[0][34]};
      sd4_q.degen <= (big == '0);
      sd4_q.idx_a <= sd3_q.idx_a;
      sd4_q.idx_b <= sd3_q.idx_b;
      sd4_q.idx_c <= sd3_q.idx_c;

      for (int i = 0; i < 3; i++) begin
        sq5_q[i] <= 62'(a_q[i]) * 62'(a_q[i]);
      end
      sd5_q <= sd4_q;

      sq6_q <= sq5_q;
      s6_q  <= 64'(sq5_q[0]) + 64'(sq5_q[1]) + 64'(sq5_q[2]);
      sd6_q <= sd5_q;
    end
  end

  // Restoring division, one quotient bit per stage and lane:
  // R = floor(a^2 * 2^30 / S), known to be at most 2^30.
  logic        dv_q   [DivSteps];
  logic [63:0] rem_q  [DivSteps][3];
  logic [30:0] quo_q  [DivSteps][3];
  logic [63:0] dsum_q [DivSteps];
  side_t       dsd_q  [DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    logic        vin;
    logic [63:0] s_in;
    side_t       sd_in;
    logic [63:0] rin  [3];
    logic [30:0] qin  [3];
    logic        bin  [3];
    logic [64:0] t    [3];
    logic [64:0] diff [3];

    // Stage inputs: the sum of squares for the first stage, else the previous stage.
    if (k == 0) begin : g_first
      always_comb begin
        vin   = v6_q;
        s_in  = s6_q;
        sd_in = sd6_q;
        for (int i = 0; i < 3; i++) begin
          rin[i] = 64'(sq6_q[i] >> 1);
          bin[i] = sq6_q[i][0];
          qin[i] = '0;
        end
      end
    end else begin : g_rest
      always_comb begin
        vin   = dv_q[k-1];
        s_in  = dsum_q[k-1];
        sd_in = dsd_q[k-1];
        for (int i = 0; i < 3; i++) begin
          rin[i] = rem_q[k-1][i];
          bin[i] = 1'b0;
          qin[i] = quo_q[k-1][i];
        end
      end
    end

    // Trial subtraction of the divisor.
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]    = {rin[i], bin[i]};
        diff[i] = t[i] - {1'b0, s_in};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (en) begin
        dv_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dsum_q[k] <= s_in;
        dsd_q[k]  <= sd_in;
        for (int i = 0; i < 3; i++) begin
          if (t[i] >= {1'b0, s_in}) begin
            rem_q[k][i] <= diff[i][63:0];
            quo_q[k][i] <= {qin[i][29:0], 1'b1};
          end else begin
            rem_q[k][i] <= t[i][63:0];
            quo_q[k][i] <= {qin[i][29:0], 1'b0};
          end
        end
      end
    end
  end

  // Digit-by-digit integer square root, one root bit per stage and lane.
  logic        sv_q   [SqrtSteps];
  logic [31:0] rad_q  [SqrtSteps][3];
  logic [16:0] srem_q [SqrtSteps][3];
  logic [15:0] root_q [SqrtSteps][3];
  side_t       ssd_q  [SqrtSteps];

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    logic        vin;
    side_t       sd_in;
    logic [31:0] radin [3];
    logic [16:0] rin   [3];
    logic [15:0] rtin  [3];
    logic [18:0] x     [3];
    logic [18:0] trial [3];
    logic [18:0] diff  [3];

    // Stage inputs: the quotient for the first stage, else the previous stage.
    if (j == 0) begin : g_first
      always_comb begin
        vin   = dv_q[DivSteps-1];
        sd_in = dsd_q[DivSteps-1];
        for (int i = 0; i < 3; i++) begin
          radin[i] = {1'b0, quo_q[DivSteps-1][i]};
          rin[i]   = '0;
          rtin[i]  = '0;
        end
      end
    end else begin : g_rest
      always_comb begin
        vin   = sv_q[j-1];
        sd_in = ssd_q[j-1];
        for (int i = 0; i < 3; i++) begin
          radin[i] = rad_q[j-1][i];
          rin[i]   = srem_q[j-1][i];
          rtin[i]  = root_q[j-1][i];
        end
      end
    end

    // Trial subtraction of the next root digit.
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        x[i]     = {rin[i], radin[i][31:30]};
        trial[i] = {1'b0, rtin[i], 2'b01};
        diff[i]  = x[i] - trial[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[j] <= 1'b0;
      end else if (en) begin
        sv_q[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ssd_q[j] <= sd_in;
        for (int i = 0; i < 3; i++) begin
          rad_q[j][i] <= {radin[i][29:0], 2'b00};
          if (x[i] >= trial[i]) begin
            srem_q[j][i] <= diff[i][16:0];
            root_q[j][i] <= {rtin[i][14:0], 1'b1};
          end else begin
            srem_q[j][i] <= x[i][16:0];
            root_q[j][i] <= {rtin[i][14:0], 1'b0};
          end
        end
      end
    end
  end

  // Output stage: q = floor((isqrt(R) + 1) / 2), signed, or zero when degenerate.
  side_t              fsd;
  logic [16:0]        rnd  [3];
  logic signed [15:0] nrm  [3];
  norm_rsp_t          out_q;

  assign fsd = ssd_q[SqrtSteps-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = 17'(root_q[SqrtSteps-1][i]) + 17'd1;
      if (fsd.degen) begin
        nrm[i] = '0;
      end else if (fsd.sgn[i]) begin
        nrm[i] = -$signed(rnd[i][16:1]);
      end else begin
        nrm[i] = $signed(rnd[i][16:1]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sv_q[SqrtSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.norm_x     <= nrm[0];
      out_q.norm_y     <= nrm[1];
      out_q.norm_z     <= nrm[2];
      out_q.out_idx_a  <= fsd.idx_a;
      out_q.out_idx_b  <= fsd.idx_b;
      out_q.out_idx_c  <= fsd.idx_c;
      out_q.degenerate <= fsd.degen;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  // A degenerate triangle always reports a zero normal.
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.degenerate) |->
      (out_q.norm_x == 16'sd0 && out_q.norm_y == 16'sd0 && out_q.norm_z == 16'sd0))
    else $error("degenerate result with a nonzero normal");

  // A proper triangle never yields an all-zero normal.
  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.degenerate) |->
      (out_q.norm_x != 16'sd0 || out_q.norm_y != 16'sd0 || out_q.norm_z != 16'sd0))
    else $error("zero normal without the degenerate flag");

  // Components stay within unit range.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |->
      (out_q.norm_x <= NormMax && out_q.norm_x >= -NormMax &&
       out_q.norm_y <= NormMax && out_q.norm_y >= -NormMax &&
       out_q.norm_z <= NormMax && out_q.norm_z >= -NormMax))
    else $error("normal component out of unit range");

endmodule
